// ----- hw/rtl/temp_pressure_compensation_top_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the compensation pipeline
// Property forms used by the top-level RTL file.
// ---------------------------------------------------------------------------
`ifndef TEMP_PRESSURE_COMPENSATION_TOP_DEFINES_SVH
`define TEMP_PRESSURE_COMPENSATION_TOP_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define TPC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication whose consequence is checked in the following cycle.
`define TPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/tpc_pkg.sv -----
// ---------------------------------------------------------------------------
// Compensation package
// Types, widths and constants shared by the compensation pipeline.
// ---------------------------------------------------------------------------
package tpc_pkg;

   localparam int unsigned CsrIndexWidth   = 2;
   localparam int unsigned CsrDataWidth    = 64;
   localparam int unsigned DivBitsPerStage = 4;

   localparam logic [CsrIndexWidth-1:0] CSR_TEMP_CALIB       = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_PRESS_CALIB_LOW  = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_PRESS_CALIB_HIGH = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_PRESS_CALIB_LAST = 2'd3;

   localparam logic [31:0] PRESS_OFFSET   = 32'd64000;
   localparam logic [31:0] PRESS_BASE     = 32'd1048576;
   localparam logic [31:0] PRESS_SCALE    = 32'd3125;
   localparam logic [31:0] SIGN_BIT       = 32'h8000_0000;
   localparam logic [31:0] P1_BIAS        = 32'd32768;
   localparam logic [31:0] ROUND_BIAS     = 32'd128;

   typedef struct packed {
      logic [31:0] t1;
      logic [31:0] t2;
      logic [31:0] t3;
      logic [31:0] p1;
      logic [31:0] p2;
      logic [31:0] p3;
      logic [31:0] p4;
      logic [31:0] p5;
      logic [31:0] p6;
      logic [31:0] p7;
      logic [31:0] p8;
      logic [31:0] p9;
   } calib_type;

   typedef struct packed {
      logic [31:0] temperature;
      logic [31:0] fine_temp;
      logic [31:0] pressure;
      logic        pressure_invalid;
   } result_type;

   function automatic logic [31:0] sx16(input logic [15:0] w);
      sx16 = {{16{w[15]}}, w};
   endfunction

   function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
      asr = 32'($signed(x) >>> n);
   endfunction

   function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] prod;
      prod  = 64'(a) * 64'(b);
      mul32 = prod[31:0];
   endfunction

endpackage

// ----- hw/rtl/temp_pressure_compensation_top.sv -----
// ---------------------------------------------------------------------------
// Temperature and pressure compensation top level
//
// Channel   Direction  Word
// req_      in         tdata = adc_temp[19:0], adc_press[39:20]
// rsp_      out        tdata = temperature, fine_temp, pressure, pressure_invalid
// csr_      in         index 0..3, 64-bit data
//
// One word enters per cycle while rsp_ is not stalled. The pipeline holds three
// temperature stages, five pressure stages, eight divider stages at four
// quotient bits each and two correction stages. Reset is synchronous and
// clears the valid bits and the calibration registers. A stall on rsp_
// freezes the whole pipeline; the output register sits in the last stage.
// ---------------------------------------------------------------------------
module temp_pressure_compensation_top
   import tpc_pkg::*;
#(
   parameter int unsigned BitsPerStage = DivBitsPerStage
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [39:0]              req_tdata,   // adc_temp, adc_press
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [103:0]             rsp_tdata,   // temperature, fine_temp, pressure, invalid
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_data
);

   logic [47:0] tcal_ff;
   logic [63:0] pl_ff, ph_ff;
   logic [15:0] p9_ff;
   calib_type   calib;
   logic        enable;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tcal_ff <= '0;
         pl_ff   <= '0;
         ph_ff   <= '0;
         p9_ff   <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TEMP_CALIB:       tcal_ff <= csr_data[47:0];
            CSR_PRESS_CALIB_LOW:  pl_ff   <= csr_data;
            CSR_PRESS_CALIB_HIGH: ph_ff   <= csr_data;
            CSR_PRESS_CALIB_LAST: p9_ff   <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   assign calib.t1 = {16'd0, tcal_ff[15:0]};
   assign calib.t2 = sx16(tcal_ff[31:16]);
   assign calib.t3 = sx16(tcal_ff[47:32]);
   assign calib.p1 = {16'd0, pl_ff[15:0]};
   assign calib.p2 = sx16(pl_ff[31:16]);
   assign calib.p3 = sx16(pl_ff[47:32]);
   assign calib.p4 = sx16(pl_ff[63:48]);
   assign calib.p5 = sx16(ph_ff[15:0]);
   assign calib.p6 = sx16(ph_ff[31:16]);
   assign calib.p7 = sx16(ph_ff[47:32]);
   assign calib.p8 = sx16(ph_ff[63:48]);
   assign calib.p9 = sx16(p9_ff);

   assign enable     = rsp_tready || !rsp_tvalid;
   assign req_tready = enable;

   logic        tv;
   logic [31:0] tf, tt;
   logic [19:0] tp;
   result_type  res;

   tpc_temp_stage u_temp (
      .clock      (clock),
      .reset      (reset),
      .enable     (enable),
      .in_valid   (req_tvalid),
      .adc_temp   (req_tdata[19:0]),
      .adc_press  (req_tdata[39:20]),
      .calib      (calib),
      .out_valid  (tv),
      .fine_temp  (tf),
      .temperature(tt),
      .out_press  (tp)
   );

   tpc_press_stage #(
      .BitsPerStage(BitsPerStage)
   ) u_press (
      .clock      (clock),
      .reset      (reset),
      .enable     (enable),
      .in_valid   (tv),
      .fine_temp  (tf),
      .temperature(tt),
      .adc_press  (tp),
      .calib      (calib),
      .out_valid  (rsp_tvalid),
      .result     (res)
   );

   assign rsp_tdata = {7'd0, res.pressure_invalid, res.pressure, res.fine_temp,
                       res.temperature};

   `include "temp_pressure_compensation_top_defines.svh"

   `TPC_ASSERT_IMPL(a_stall_holds_ready, clock, reset, rsp_tvalid && !rsp_tready, !req_tready, "input taken during output stall")
   `TPC_ASSERT_NEXT(a_stall_holds_word, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled word changed")
   `TPC_ASSERT_IMPL(a_invalid_zero, clock, reset, rsp_tvalid && rsp_tdata[96], rsp_tdata[95:64] == 32'd0, "invalid pressure not zero")

endmodule

// ----- hw/rtl/tpc_divider.sv -----
// ---------------------------------------------------------------------------
// Pipelined unsigned divider: radix-2 restoring division,
// BitsPerStage quotient bits per stage, one item per cycle while enable is high.
// ---------------------------------------------------------------------------
module tpc_divider
   import tpc_pkg::*;
#(
   parameter int unsigned BitsPerStage = DivBitsPerStage,
   parameter int unsigned TagWidth     = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  logic                in_valid,
   input  logic [31:0]         in_num,
   input  logic [31:0]         in_den,
   input  logic [TagWidth-1:0] in_tag,
   output logic                out_valid,
   output logic [31:0]         out_quo,
   output logic [TagWidth-1:0] out_tag
);

   localparam int unsigned Stages = 32 / BitsPerStage;

   logic [Stages:0]               vld;
   logic [Stages:0][31:0]         rem;
   logic [Stages:0][31:0]         num;
   logic [Stages:0][31:0]         den;
   logic [Stages:0][TagWidth-1:0] tag;

   assign vld[0] = in_valid;
   assign rem[0] = '0;
   assign num[0] = in_num;
   assign den[0] = in_den;
   assign tag[0] = in_tag;

   for (genvar s = 0; s < Stages; s++) begin : g_stage
      logic [31:0] rem_in, num_in;
      logic [31:0] rem_ff, num_ff, den_ff;
      logic [TagWidth-1:0] tag_ff;
      logic vld_ff;

      always_comb begin
         logic [32:0] r;
         logic [31:0] n;
         r = {1'b0, rem[s]};
         n = num[s];
         for (int k = 0; k < BitsPerStage; k++) begin
            r = {r[31:0], n[31]};
            n = {n[30:0], 1'b0};
            if (r >= {1'b0, den[s]}) begin
               r    = r - {1'b0, den[s]};
               n[0] = 1'b1;
            end
         end
         rem_in = r[31:0];
         num_in = n;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (enable) begin
            vld_ff <= vld[s];
         end
         if (enable) begin
            rem_ff <= rem_in;
            num_ff <= num_in;
            den_ff <= den[s];
            tag_ff <= tag[s];
         end
      end

      assign vld[s+1] = vld_ff;
      assign rem[s+1] = rem_ff;
      assign num[s+1] = num_ff;
      assign den[s+1] = den_ff;
      assign tag[s+1] = tag_ff;
   end

   assign out_valid = vld[Stages];
   assign out_quo   = num[Stages];
   assign out_tag   = tag[Stages];

endmodule

// ----- hw/rtl/tpc_temp_stage.sv -----
// ---------------------------------------------------------------------------
// Temperature compensation stages
// Computes fine temperature and temperature over three register stages.
// ---------------------------------------------------------------------------
module tpc_temp_stage
   import tpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        enable,
   input  logic        in_valid,
   input  logic [19:0] adc_temp,
   input  logic [19:0] adc_press,
   input  calib_type   calib,
   output logic        out_valid,
   output logic [31:0] fine_temp,
   output logic [31:0] temperature,
   output logic [19:0] out_press
);

   logic [31:0] a_in, dd_in, d_in;
   logic [31:0] a_ff, dd_ff;
   logic [31:0] tf_in, tf_ff;
   logic [31:0] temp_in, temp_ff, tf2_ff;
   logic [19:0] p1_ff, p2_ff, p3_ff;
   logic [2:0]  vld_ff;

   always_comb begin
      d_in  = 32'(adc_temp >> 4) - calib.t1;
      a_in  = asr(mul32(32'(adc_temp >> 3) - (calib.t1 << 1), calib.t2), 11);
      dd_in = asr(mul32(d_in, d_in), 12);
      tf_in = a_ff + asr(mul32(dd_ff, calib.t3), 14);
      temp_in = asr(mul32(tf_ff, 32'd5) + ROUND_BIAS, 8);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
      if (enable) begin
         a_ff    <= a_in;
         dd_ff   <= dd_in;
         p1_ff   <= adc_press;
         tf_ff   <= tf_in;
         p2_ff   <= p1_ff;
         temp_ff <= temp_in;
         tf2_ff  <= tf_ff;
         p3_ff   <= p2_ff;
      end
   end

   assign out_valid   = vld_ff[2];
   assign fine_temp   = tf2_ff;
   assign temperature = temp_ff;
   assign out_press   = p3_ff;

endmodule

// ----- hw/rtl/tpc_press_stage.sv -----
// ---------------------------------------------------------------------------
// Pressure compensation stages
// Divisor and numerator, pipelined division and final correction.
// ---------------------------------------------------------------------------
module tpc_press_stage
   import tpc_pkg::*;
#(
   parameter int unsigned BitsPerStage = DivBitsPerStage
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        enable,
   input  logic        in_valid,
   input  logic [31:0] fine_temp,
   input  logic [31:0] temperature,
   input  logic [19:0] adc_press,
   input  calib_type   calib,
   output logic        out_valid,
   output result_type  result
);

   localparam int unsigned TagW = 32 + 32 + 1 + 1;

   // Stage A
   logic [31:0] a_in, q_in, qq_in;
   logic [31:0] a_a, q_a, qq_a, tf_a, t_a;
   logic [19:0] ap_a;
   // Stage B
   logic [31:0] b6_a, b5_a, pc3_in, pc2_in;
   logic [31:0] b6_ff, b5_ff, pc3_ff, pc2_ff, tf_b, t_b;
   logic [19:0] ap_b;
   // Stage C
   logic [31:0] bb_in, sum_in;
   logic [31:0] bb_c, sum_c, tf_c, t_c;
   logic [19:0] ap_c;
   // Stage D
   logic [31:0] div_in, nsub_in;
   logic [31:0] div_d, nsub_d, tf_d, t_d;
   // Stage E
   logic [31:0] num_in, num_e, div_e, tf_e, t_e;
   logic [4:0]  vld_ff;

   always_comb begin
      a_in  = asr(fine_temp, 1) - PRESS_OFFSET;
      q_in  = asr(a_in, 2);
      qq_in = mul32(q_in, q_in);
      b6_a  = mul32(asr(qq_a, 11), calib.p6);
      b5_a  = mul32(a_a, calib.p5) << 1;
      pc3_in = asr(mul32(calib.p3, asr(qq_a, 13)), 3);
      pc2_in = asr(mul32(calib.p2, a_a), 1);
      bb_in  = asr(b6_ff + b5_ff, 2) + (calib.p4 << 16);
      sum_in = P1_BIAS + asr(pc3_ff + pc2_ff, 18);
      div_in  = asr(mul32(sum_c, calib.p1), 15);
      nsub_in = (PRESS_BASE - 32'(ap_c)) - asr(bb_c, 12);
      num_in  = mul32(nsub_d, PRESS_SCALE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= {vld_ff[3:0], in_valid};
      end
      if (enable) begin
         a_a <= a_in; q_a <= q_in; qq_a <= qq_in;
         tf_a <= fine_temp; t_a <= temperature; ap_a <= adc_press;
         b6_ff <= b6_a; b5_ff <= b5_a; pc3_ff <= pc3_in; pc2_ff <= pc2_in;
         tf_b <= tf_a; t_b <= t_a; ap_b <= ap_a;
         bb_c <= bb_in; sum_c <= sum_in; tf_c <= tf_b; t_c <= t_b; ap_c <= ap_b;
         div_d <= div_in; nsub_d <= nsub_in; tf_d <= tf_c; t_d <= t_c;
         num_e <= num_in; div_e <= div_d; tf_e <= tf_d; t_e <= t_d;
      end
   end

   logic [31:0]     dnum;
   logic            big;
   logic [TagW-1:0] tag_o;
   logic            dv_o;
   logic [31:0]     quo_o;

   assign big  = num_e >= SIGN_BIT;
   assign dnum = big ? num_e : (num_e << 1);

   tpc_divider #(
      .BitsPerStage(BitsPerStage),
      .TagWidth    (TagW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .in_valid (vld_ff[4]),
      .in_num   (dnum),
      .in_den   (div_e),
      .in_tag   ({t_e, tf_e, big, (div_e == '0)}),
      .out_valid(dv_o),
      .out_quo  (quo_o),
      .out_tag  (tag_o)
   );

   // Final correction, two stages.
   logic [31:0] p_in, p_f, ca_in, cb_in, ca_ff, cb_ff, t_f, tf_f, t_g, tf_g;
   logic [31:0] pr_in, pr_ff;
   logic        inv_f, inv_g;
   logic [1:0]  fv_ff;
   logic [31:0] p3w;

   always_comb begin
      p_in  = tag_o[0] ? '0 : (tag_o[1] ? (quo_o << 1) : quo_o);
      p3w   = p_in >> 3;
      ca_in = mul32(p3w, p3w);
      cb_in = asr(mul32(p_in >> 2, calib.p8), 13);
      pr_in = inv_f ? '0 :
              p_f + asr(asr(mul32(calib.p9, ca_ff >> 13), 12) + cb_ff + calib.p7, 4);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= '0;
      end else if (enable) begin
         fv_ff <= {fv_ff[0], dv_o};
      end
      if (enable) begin
         p_f <= p_in; inv_f <= tag_o[0];
         t_f <= tag_o[TagW-1 -: 32]; tf_f <= tag_o[33:2];
         ca_ff <= ca_in; cb_ff <= cb_in;
         pr_ff <= pr_in; inv_g <= inv_f; t_g <= t_f; tf_g <= tf_f;
      end
   end

   assign out_valid               = fv_ff[1];
   assign result.temperature      = t_g;
   assign result.fine_temp        = tf_g;
   assign result.pressure         = pr_ff;
   assign result.pressure_invalid = inv_g;

endmodule

// ----- test/tb_temp_pressure_compensation_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Testbench for the temperature and pressure compensation top level
// Streams raw sample words through the block under several calibration
// settings and checks every result word against a local compensation model.
// ---------------------------------------------------------------------------
module tb_temp_pressure_compensation_top;
   import tpc_pkg::*;

   localparam int unsigned CycleLimit = 400000;
   localparam int unsigned DrainWait  = 40;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [39:0]              req_tdata;   // adc_temp[19:0], adc_press[39:20]
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [103:0]             rsp_tdata;   // temperature, fine_temp, pressure, invalid
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_data;

   logic [63:0] cal_temp, cal_plow, cal_phigh, cal_plast;
   result_type  expected_q[$];
   int unsigned fails;
   int unsigned cycles;
   int unsigned hold_req;
   int unsigned rx_wait;
   bit          idle_on;

   temp_pressure_compensation_top u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic logic [31:0] sra32(input logic [31:0] x, input int n);
      sra32 = $signed(x) >>> n;
   endfunction

   function automatic logic [31:0] m32(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] prod;
      prod = {32'd0, a} * {32'd0, b};
      m32  = prod[31:0];
   endfunction

   function automatic logic [31:0] sx(input logic [15:0] w);
      sx = {{16{w[15]}}, w};
   endfunction

   function automatic result_type compensate(input logic [19:0] at, input logic [19:0] ap);
      logic [31:0] ut, up, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [31:0] a, b, d, q, tf, num, p;
      result_type r;
      ut = {12'd0, at};
      up = {12'd0, ap};
      t1 = {16'd0, cal_temp[15:0]};
      t2 = sx(cal_temp[31:16]);
      t3 = sx(cal_temp[47:32]);
      p1 = {16'd0, cal_plow[15:0]};
      p2 = sx(cal_plow[31:16]);
      p3 = sx(cal_plow[47:32]);
      p4 = sx(cal_plow[63:48]);
      p5 = sx(cal_phigh[15:0]);
      p6 = sx(cal_phigh[31:16]);
      p7 = sx(cal_phigh[47:32]);
      p8 = sx(cal_phigh[63:48]);
      p9 = sx(cal_plast[15:0]);
      a  = sra32(m32((ut >> 3) - (t1 << 1), t2), 11);
      d  = (ut >> 4) - t1;
      b  = sra32(m32(sra32(m32(d, d), 12), t3), 14);
      tf = a + b;
      r.fine_temp   = tf;
      r.temperature = sra32(m32(tf, 32'd5) + 32'd128, 8);
      a = sra32(tf, 1) - 32'd64000;
      q = sra32(a, 2);
      b = m32(sra32(m32(q, q), 11), p6);
      b = b + (m32(a, p5) << 1);
      b = sra32(b, 2) + (p4 << 16);
      a = sra32(sra32(m32(p3, sra32(m32(q, q), 13)), 3) + sra32(m32(p2, a), 1), 18);
      a = sra32(m32(32'd32768 + a, p1), 15);
      if (a == 32'd0) begin
         r.pressure = 32'd0;
         r.pressure_invalid = 1'b1;
      end else begin
         num = m32((32'd1048576 - up) - sra32(b, 12), 32'd3125);
         if (num < 32'h8000_0000) begin
            p = (num << 1) / a;
         end else begin
            p = (num / a) * 32'd2;
         end
         a = sra32(m32(p9, m32(p >> 3, p >> 3) >> 13), 12);
         b = sra32(m32(p >> 2, p8), 13);
         r.pressure = p + sra32(a + b + p7, 4);
         r.pressure_invalid = 1'b0;
      end
      return r;
   endfunction

   task automatic send_sample(input logic [19:0] at, input logic [19:0] ap);
      int unsigned gap;
      gap = idle_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {ap, at};
      do @(posedge clock); while (!req_tready);
      expected_q.push_back(compensate(at, ap));
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_q.size() > 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CsrIndexWidth-1:0] idx, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_TEMP_CALIB:       cal_temp  = {16'd0, value[47:0]};
         CSR_PRESS_CALIB_LOW:  cal_plow  = value;
         CSR_PRESS_CALIB_HIGH: cal_phigh = value;
         CSR_PRESS_CALIB_LAST: cal_plast = {48'd0, value[15:0]};
         default: ;
      endcase
   endtask

   task automatic load_calib(input logic [63:0] tc, input logic [63:0] pl,
                             input logic [63:0] ph, input logic [63:0] pz);
      wait_idle();
      write_csr(CSR_TEMP_CALIB, tc);
      write_csr(CSR_PRESS_CALIB_LOW, pl);
      write_csr(CSR_PRESS_CALIB_HIGH, ph);
      write_csr(CSR_PRESS_CALIB_LAST, pz);
      csr_valid <= 1'b0;
   endtask

   task automatic load_typical();
      load_calib({16'd0, 16'hFC18, 16'd26435, 16'd27504},
                 {16'd2855, 16'd3024, 16'hD643, 16'd36477},
                 {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140},
                 64'd6000);
   endtask

   task automatic test_directed();
      // Zero calibration gives a zero divisor, so the pressure is flagged.
      send_sample(20'h00000, 20'h00000);
      send_sample(20'hFFFFF, 20'hFFFFF);
      load_typical();
      send_sample(20'd519888, 20'd415148);
      send_sample(20'h00000, 20'h00000);
      send_sample(20'hFFFFF, 20'hFFFFF);
      send_sample(20'hAAAAA, 20'h55555);
      send_sample(20'h55555, 20'hAAAAA);
      send_sample(20'h80000, 20'h7FFFF);
      load_calib(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send_sample(20'h00000, 20'hFFFFF);
      send_sample(20'hFFFFF, 20'h00000);
      send_sample(20'h12345, 20'h6789A);
      load_calib({16'd0, 16'h8000, 16'h8000, 16'hFFFF},
                 {16'h7FFF, 16'h7FFF, 16'h8000, 16'h0001},
                 {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF},
                 64'h8000);
      send_sample(20'h00000, 20'h00000);
      send_sample(20'hFFFFF, 20'hFFFFF);
      send_sample(20'h7FFFF, 20'h80000);
      load_calib({16'd0, 16'h7FFF, 16'h7FFF, 16'h0000}, 64'h0, 64'h0, 64'h7FFF);
      send_sample(20'hFFFFF, 20'h00000);
      send_sample(20'h00000, 20'hFFFFF);
   endtask

   task automatic test_random();
      logic [63:0] tc, pl, ph;
      for (int ph_n = 0; ph_n < 12; ph_n++) begin
         tc = {$urandom, $urandom};
         pl = {$urandom, $urandom};
         ph = {$urandom, $urandom};
         if (ph_n % 3 == 0) begin
            load_typical();
         end else begin
            if (ph_n == 4) pl[15:0] = 16'd0;
            load_calib(tc, pl, ph, {$urandom, $urandom});
         end
         idle_on = (ph_n % 4 != 2);
         for (int i = 0; i < 115; i++) begin
            if (ph_n % 3 == 0 && i % 2 == 0) begin
               send_sample(20'd519888 + 20'($urandom_range(0, 131071)) - 20'd65536,
                           20'd415148 + 20'($urandom_range(0, 131071)) - 20'd65536);
            end else begin
               send_sample(20'($urandom), 20'($urandom));
            end
         end
      end
      idle_on = 1'b1;
   endtask

   task automatic test_backpressure();
      load_typical();
      idle_on  = 1'b0;
      hold_req = 300;
      for (int i = 0; i < 60; i++) send_sample(20'($urandom), 20'($urandom));
      idle_on = 1'b1;
   endtask

   always @(posedge clock) begin
      int unsigned w;
      if (hold_req > 0) begin
         rx_wait  = hold_req;
         hold_req = 0;
      end
      if (rx_wait > 0) begin
         rx_wait--;
         rsp_tready <= 1'b0;
      end else if (rsp_tvalid && rsp_tready && idle_on) begin
         w = $urandom_range(0, 5);
         rsp_tready <= (w == 0);
         rx_wait = (w > 0) ? w - 1 : 0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_q.size() == 0) begin
            $error("unexpected result word %h", rsp_tdata);
            fails++;
         end else begin
            exp_r = expected_q.pop_front();
            if (rsp_tdata[31:0] !== exp_r.temperature) begin
               $error("temperature expected %h actual %h", exp_r.temperature,
                      rsp_tdata[31:0]);
               fails++;
            end
            if (rsp_tdata[63:32] !== exp_r.fine_temp) begin
               $error("fine_temp expected %h actual %h", exp_r.fine_temp, rsp_tdata[63:32]);
               fails++;
            end
            if (rsp_tdata[95:64] !== exp_r.pressure) begin
               $error("pressure expected %h actual %h", exp_r.pressure, rsp_tdata[95:64]);
               fails++;
            end
            if (rsp_tdata[96] !== exp_r.pressure_invalid) begin
               $error("pressure_invalid expected %b actual %b", exp_r.pressure_invalid,
                      rsp_tdata[96]);
               fails++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("tb_temp_pressure_compensation_top: FAIL");
         $finish;
      end
   end

   initial begin
      fails = 0;
      cycles = 0;
      hold_req = 0;
      rx_wait = 0;
      idle_on = 1'b1;
      cal_temp = 64'd0;
      cal_plow = 64'd0;
      cal_phigh = 64'd0;
      cal_plast = 64'd0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= 40'd0;
      rsp_tready <= 1'b0;
      csr_valid  <= 1'b0;
      csr_index  <= CSR_TEMP_CALIB;
      csr_data   <= 64'd0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random();
      test_backpressure();
      wait_idle();
      if (fails == 0) begin
         $display("tb_temp_pressure_compensation_top: PASS");
      end else begin
         $display("tb_temp_pressure_compensation_top: FAIL");
      end
      $finish;
   end

endmodule
